/* src/sobel_pkg.sv */
// Shared types, constants and the arctangent table of the Sobel gradient block.
package sobel_pkg;

	localparam int CFG_W        = 11;
	localparam int PIX_W        = 8;
	localparam int GRAD_W       = 11;
	localparam int SQ_W         = 22;
	localparam int MAG_W        = 11;
	localparam int ANGLE_W      = 16;
	localparam int POS_W        = 10;
	localparam int CORDIC_STEPS = 24;
	localparam int SQRT_STEPS   = 11;
	localparam int STEP_W       = 5;
	localparam int XY_W         = 34;
	localparam int Z_W          = 29;
	localparam int INPUT_SCALE  = 20;
	localparam int TABLE_FRAC   = 24;
	localparam int MAX_HEIGHT   = 1024;

	localparam logic signed [Z_W-1:0] PI_Q      = 29'sd52707179;
	localparam logic signed [Z_W-1:0] HALF_PI_Q = 29'sd26353589;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_GRAD,
		ST_SQR,
		ST_ITER,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic              accept;
		logic              load;
		logic              grad;
		logic              init;
		logic              iter;
		logic [STEP_W-1:0] step;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic emit;
		logic out_free;
	} dp_sts_t;

	// atan(2^-i) with 24 fraction bits.
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			5'd0:  v = 29'sd13176795;
			5'd1:  v = 29'sd7778716;
			5'd2:  v = 29'sd4110060;
			5'd3:  v = 29'sd2086331;
			5'd4:  v = 29'sd1047214;
			5'd5:  v = 29'sd524117;
			5'd6:  v = 29'sd262123;
			5'd7:  v = 29'sd131069;
			5'd8:  v = 29'sd65536;
			5'd9:  v = 29'sd32768;
			5'd10: v = 29'sd16384;
			5'd11: v = 29'sd8192;
			5'd12: v = 29'sd4096;
			5'd13: v = 29'sd2048;
			5'd14: v = 29'sd1024;
			5'd15: v = 29'sd512;
			5'd16: v = 29'sd256;
			5'd17: v = 29'sd128;
			5'd18: v = 29'sd64;
			5'd19: v = 29'sd32;
			5'd20: v = 29'sd16;
			5'd21: v = 29'sd8;
			5'd22: v = 29'sd4;
			5'd23: v = 29'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* src/sobel_gradient_stream_top.sv */
// Top level of the streaming 3x3 Sobel gradient block.
// Items are taken one at a time. An item on a border pixel gives no result, and the
// controller returns to idle once it is loaded. An interior item is held until its
// result enters the output register, which waits while the sink stalls; its run is
// set by the 24-step shared CORDIC unit that the square root runs beside.
// Reset clears the counters, the window and the output valid, loads width 640 and
// height 480, and leaves the line stores holding whatever they held.
module sobel_gradient_stream_top
	import sobel_pkg::*;
#(
	parameter int MAX_WIDTH       = 1024,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [PIX_W-1:0]          pixel,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [GRAD_W-1:0]  grad_x,
	output logic signed [GRAD_W-1:0]  grad_y,
	output logic [MAG_W-1:0]          magnitude,
	output logic signed [ANGLE_W-1:0] angle,
	output logic [POS_W-1:0]          center_col,
	output logic [POS_W-1:0]          center_row,
	output logic                      frame_last
);

	// The controller takes one item at a time from the idle state; every
	// other step of the item is a command to the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;

	sobel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the line stores, the window and the arithmetic units,
	// and an output register so that a finished result may wait for the sink
	// while the next item is already taken in.
	sobel_dp #(
		.MAX_WIDTH       (MAX_WIDTH),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.grad_x     (grad_x),
		.grad_y     (grad_y),
		.magnitude  (magnitude),
		.angle      (angle),
		.center_col (center_col),
		.center_row (center_row),
		.frame_last (frame_last)
	);

endmodule

/* src/sobel_ctrl.sv */
// Controller state machine that sequences one pixel item through the datapath.
module sobel_ctrl
	import sobel_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t       state_q, state_nxt;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_ITER) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				state_nxt = sts.emit ? ST_GRAD : ST_IDLE;
			end
			ST_GRAD: state_nxt = ST_SQR;
			ST_SQR:  state_nxt = ST_ITER;
			ST_ITER: begin
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.load     = (state_q == ST_LOAD);
		cmd.grad     = (state_q == ST_GRAD);
		cmd.init     = (state_q == ST_SQR);
		cmd.iter     = (state_q == ST_ITER);
		cmd.step     = step_q;
		cmd.out_load = (state_q == ST_DONE) && sts.out_free;
	end

endmodule

/* src/sobel_dp.sv */
// Datapath: line stores, window, counters, gradients, square root and CORDIC angle unit.
module sobel_dp
	import sobel_pkg::*;
#(
	parameter int MAX_WIDTH       = 1024,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_sts_t                   sts,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic [PIX_W-1:0]          pixel,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [GRAD_W-1:0]  grad_x,
	output logic signed [GRAD_W-1:0]  grad_y,
	output logic [MAG_W-1:0]          magnitude,
	output logic signed [ANGLE_W-1:0] angle,
	output logic [POS_W-1:0]          center_col,
	output logic [POS_W-1:0]          center_row,
	output logic                      frame_last
);

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
	localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
	localparam int RSH = TABLE_FRAC - ANGLE_FRAC_BITS;

	// Configuration registers.
	logic [CFG_W-1:0] width_q, height_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH)  width_q  <= cfg_data;
			if (cfg_index == REG_HEIGHT) height_q <= cfg_data;
		end
	end

	logic [WW-1:0]    w_raw, w_eff;
	logic [CFG_W-1:0] h_eff;
	always_comb begin
		w_raw = WW'(width_q);
		if (w_raw < WW'(3))              w_eff = WW'(3);
		else if (w_raw > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else                             w_eff = w_raw;
		if (height_q < CFG_W'(3))               h_eff = CFG_W'(3);
		else if (height_q > CFG_W'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
		else                                    h_eff = height_q;
	end

	// Position counters.
	logic [CW-1:0]    col_q;
	logic [POS_W-1:0] row_q;
	logic [WW-1:0]    col_ext, col_inc;
	logic [CFG_W-1:0] row_inc;
	assign col_ext = WW'(col_q);
	assign col_inc = col_ext + WW'(1);
	assign row_inc = CFG_W'(row_q) + CFG_W'(1);
	assign sts.emit = (row_q >= POS_W'(2)) && (col_q >= CW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// Line stores with registered reads, read on the accept edge.
	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] up_rd_q, mid_rd_q, pix_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			up_rd_q  <= upper_mem[col_q];
			mid_rd_q <= middle_mem[col_q];
			pix_q    <= pixel;
		end
		if (cmd.load) begin
			upper_mem[col_q]  <= mid_rd_q;
			middle_mem[col_q] <= pix_q;
		end
	end

	// 3x3 window, row 0 on top, column 2 newest.
	logic [PIX_W-1:0] win_q [3][3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (cmd.load) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up_rd_q;
			win_q[1][2] <= mid_rd_q;
			win_q[2][2] <= pix_q;
		end
	end

	// Position of the centre pixel, held with the item.
	logic [POS_W-1:0] ccol_q, crow_q;
	logic             last_q;
	logic [WW-1:0]    col_dec;
	assign col_dec = col_ext - WW'(1);
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ccol_q <= col_dec[POS_W-1:0];
			crow_q <= row_q - POS_W'(1);
			last_q <= (row_inc == h_eff) && (col_inc == w_eff);
		end
	end

	// Sobel gradients.
	logic signed [GRAD_W-1:0] gx_q, gy_q;
	logic [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
	always_comb begin
		gx_pos = GRAD_W'(win_q[0][2]) + GRAD_W'({win_q[1][2], 1'b0}) + GRAD_W'(win_q[2][2]);
		gx_neg = GRAD_W'(win_q[0][0]) + GRAD_W'({win_q[1][0], 1'b0}) + GRAD_W'(win_q[2][0]);
		gy_pos = GRAD_W'(win_q[2][0]) + GRAD_W'({win_q[2][1], 1'b0}) + GRAD_W'(win_q[2][2]);
		gy_neg = GRAD_W'(win_q[0][0]) + GRAD_W'({win_q[0][1], 1'b0}) + GRAD_W'(win_q[0][2]);
	end
	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			gx_q <= $signed(gx_pos - gx_neg);
			gy_q <= $signed(gy_pos - gy_neg);
		end
	end

	// Square root: two radicand bits per step, restoring form.
	logic [SQ_W-1:0]    sqv_q;
	logic [MAG_W+2:0]   rem_q;
	logic [MAG_W-1:0]   root_q;
	logic [MAG_W+2:0]   rem_sh, trial;
	logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
	assign gx_sq = gx_q * gx_q;
	assign gy_sq = gy_q * gy_q;
	assign rem_sh = {rem_q[MAG_W:0], sqv_q[SQ_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			sqv_q  <= SQ_W'($unsigned(gx_sq)) + SQ_W'($unsigned(gy_sq));
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.iter && (cmd.step < STEP_W'(SQRT_STEPS))) begin
			sqv_q <= {sqv_q[SQ_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	// CORDIC vectoring for the angle.
	logic signed [XY_W-1:0] x_q, y_q, xs, ys;
	logic signed [Z_W-1:0]  z_q;
	logic                   bypass_q;
	logic signed [GRAD_W-1:0] gx_abs, gy_adj;
	assign xs = x_q >>> cmd.step;
	assign ys = y_q >>> cmd.step;
	assign gx_abs = gx_q[GRAD_W-1] ? -gx_q : gx_q;
	assign gy_adj = gx_q[GRAD_W-1] ? -gy_q : gy_q;

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			x_q <= XY_W'(gx_abs) <<< INPUT_SCALE;
			y_q <= XY_W'(gy_adj) <<< INPUT_SCALE;
			if (gy_q == '0) begin
				bypass_q <= 1'b1;
				z_q      <= gx_q[GRAD_W-1] ? PI_Q : '0;
			end else if (gx_q == '0) begin
				bypass_q <= 1'b1;
				z_q      <= gy_q[GRAD_W-1] ? -HALF_PI_Q : HALF_PI_Q;
			end else begin
				bypass_q <= 1'b0;
				if (gx_q[GRAD_W-1]) z_q <= gy_q[GRAD_W-1] ? -PI_Q : PI_Q;
				else                z_q <= '0;
			end
		end else if (cmd.iter && !bypass_q) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_entry(cmd.step);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_entry(cmd.step);
			end
		end
	end

	logic signed [Z_W-1:0] z_rnd, z_sh;
	assign z_rnd = z_q + (Z_W'(1) <<< (RSH - 1));
	assign z_sh  = z_rnd >>> RSH;

	// Output register.
	logic out_valid_q;
	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			grad_x     <= gx_q;
			grad_y     <= gy_q;
			magnitude  <= root_q;
			angle      <= z_sh[ANGLE_W-1:0];
			center_col <= ccol_q;
			center_row <= crow_q;
			frame_last <= last_q;
		end
	end

endmodule
